[rtl/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression core.
package gbs_pkg;

  localparam logic [15:0] OVERLAP_THRESHOLD_RESET = 16'd45875;
  localparam logic [8:0]  KEEP_LIMIT_RESET        = 9'd0;

  localparam logic [0:0] CFG_OVERLAP_THRESHOLD = 1'd0;
  localparam logic [0:0] CFG_KEEP_LIMIT        = 1'd1;

  localparam logic [1:0] VERDICT_KEPT       = 2'd0;
  localparam logic [1:0] VERDICT_SUPPRESSED = 2'd1;
  localparam logic [1:0] VERDICT_OVER_LIMIT = 2'd2;
  localparam logic [1:0] VERDICT_OVERFLOW   = 2'd3;

  // Back-end state machine, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } back_state_t;

endpackage

[rtl/gbs_front.sv]
// Front end: takes a box word, computes its area and queues it for the back end.
module gbs_front
  import gbs_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_take,
  input  logic                     in_start_of_set,
  input  logic [COORD_WIDTH-1:0]   in_box_left,
  input  logic [COORD_WIDTH-1:0]   in_box_top,
  input  logic [COORD_WIDTH-1:0]   in_box_right,
  input  logic [COORD_WIDTH-1:0]   in_box_bottom,
  output logic                     q_valid,
  input  logic                     q_pop,
  output logic                     q_sos,
  output logic [4*COORD_WIDTH-1:0] q_box,
  output logic [2*COORD_WIDTH+1:0] q_area
);

  localparam int EW = COORD_WIDTH + 1;

  logic                     valid_r;
  logic                     sos_r;
  logic [4*COORD_WIDTH-1:0] box_r;
  logic [EW-1:0]            ew_r;
  logic [EW-1:0]            eh_r;
  logic                     pend_r;
  logic [EW-1:0]            ew_nxt;
  logic [EW-1:0]            eh_nxt;
  logic [2*COORD_WIDTH+1:0] area_r;

  // Extent plus a pad of 16, clamped at zero.
  function automatic logic [EW-1:0] ext(input logic [COORD_WIDTH-1:0] lo,
                                        input logic [COORD_WIDTH-1:0] hi);
    logic [EW:0] d;
    d = {2'b00, hi} - {2'b00, lo} + (EW+1)'(16);
    return d[EW] ? '0 : d[EW-1:0];
  endfunction

  assign ew_nxt = ext(in_box_left, in_box_right);
  assign eh_nxt = ext(in_box_top, in_box_bottom);

  // Two stages: extents registered, then the area product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      pend_r <= in_take;
      if (pend_r) valid_r <= 1'b1;
      else if (q_pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sos_r <= in_start_of_set;
      box_r <= {in_box_left, in_box_top, in_box_right, in_box_bottom};
      ew_r  <= ew_nxt;
      eh_r  <= eh_nxt;
    end
    if (pend_r) area_r <= (2*COORD_WIDTH+2)'(ew_r * eh_r);
  end

  assign q_valid = valid_r;
  assign q_sos   = sos_r;
  assign q_box   = box_r;
  assign q_area  = area_r;

endmodule

[rtl/gbs_back.sv]
// Back end: scans kept boxes one a cycle and issues the verdict.
module gbs_back
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT    = 256,
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  logic                     q_sos,
  input  logic [4*COORD_WIDTH-1:0] q_box,
  input  logic [2*COORD_WIDTH+1:0] q_area,
  input  logic [15:0]              overlap_threshold,
  input  logic [8:0]               keep_limit,
  output logic                     idle,
  output logic                     out_valid,
  output logic [1:0]               out_verdict,
  output logic [8:0]               out_kept_so_far
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = 2*CW + 2;
  localparam int IW = $clog2(MAX_KEPT);
  localparam int NW = $clog2(MAX_KEPT + 1);
  localparam int LW = (NW > 9) ? NW : 9;
  localparam int EW = CW + 1;
  localparam int PW = AW + 17;

  back_state_t state_r, state_nxt;

  logic [4*CW-1:0] box_mem [MAX_KEPT];
  logic [AW-1:0]   area_mem [MAX_KEPT];

  logic [NW-1:0]   count_r;
  logic [NW-1:0]   idx_r;
  logic [4*CW-1:0] cur_box_r;
  logic [AW-1:0]   cur_area_r;
  logic [4*CW-1:0] rd_box_r;
  logic [AW-1:0]   rd_area_r;
  logic            rd_ok_r;
  logic [EW-1:0]   iw_r, ih_r;
  logic [AW-1:0]   ka_r;
  logic            s1_ok_r;
  logic [AW-1:0]   inter_r;
  logic [AW:0]     uni_r;
  logic            s2_ok_r;
  logic            hit_r;
  logic            valid_r;
  logic [1:0]      verdict_r;
  logic [8:0]      kept_r;

  logic [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic [CW-1:0] ix1, iy1, ix2, iy2;
  logic [EW:0]   dw, dh;
  logic [PW-1:0] lhs, rhs;
  logic [AW-1:0] inter_nxt;
  logic          pipe_busy;
  logic          scan_more;
  logic          count_full;
  logic          over_limit;

  assign {ax1, ay1, ax2, ay2} = rd_box_r;
  assign {bx1, by1, bx2, by2} = cur_box_r;
  assign ix1 = (ax1 > bx1) ? ax1 : bx1;
  assign iy1 = (ay1 > by1) ? ay1 : by1;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;
  assign dw  = {2'b00, ix2} - {2'b00, ix1} + (EW+1)'(16);
  assign dh  = {2'b00, iy2} - {2'b00, iy1} + (EW+1)'(16);
  assign inter_nxt = AW'(iw_r * ih_r);
  assign lhs = {1'b0, inter_r, 16'd0};
  assign rhs = PW'(uni_r * overlap_threshold);

  assign scan_more  = (idx_r < count_r) && !hit_r;
  assign pipe_busy  = rd_ok_r || s1_ok_r || s2_ok_r;
  assign count_full = (count_r >= NW'(MAX_KEPT));
  assign over_limit = (keep_limit != '0) && (LW'(count_r) >= LW'(keep_limit))
                      && !count_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_SCAN;
      ST_SCAN:  if (!scan_more) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop = (state_r == ST_LOAD);
  assign idle  = (state_r == ST_IDLE) && !q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      rd_ok_r <= 1'b0;
      s1_ok_r <= 1'b0;
      s2_ok_r <= 1'b0;
      hit_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= 1'b0;
      rd_ok_r <= (state_r == ST_SCAN) && scan_more;
      s1_ok_r <= rd_ok_r && !hit_r;
      s2_ok_r <= s1_ok_r && !hit_r;
      if (s2_ok_r && uni_r != '0 && lhs >= rhs) hit_r <= 1'b1;
      if (state_r == ST_SCAN && scan_more) idx_r <= idx_r + 1'b1;
      if (state_r == ST_LOAD) begin
        idx_r <= '0;
        hit_r <= 1'b0;
        if (q_sos) count_r <= '0;
      end
      if (state_r == ST_DONE) begin
        valid_r <= 1'b1;
        if (!hit_r && !over_limit && !count_full) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      cur_box_r  <= q_box;
      cur_area_r <= q_area;
    end
    if (state_r == ST_SCAN && scan_more) begin
      rd_box_r  <= box_mem[idx_r[IW-1:0]];
      rd_area_r <= area_mem[idx_r[IW-1:0]];
    end
    iw_r    <= dw[EW] ? '0 : dw[EW-1:0];
    ih_r    <= dh[EW] ? '0 : dh[EW-1:0];
    ka_r    <= rd_area_r;
    inter_r <= inter_nxt;
    uni_r   <= {1'b0, ka_r} + {1'b0, cur_area_r} - {1'b0, inter_nxt};
    if (state_r == ST_DONE) begin
      if (hit_r) begin
        verdict_r <= VERDICT_SUPPRESSED;
        kept_r    <= 9'(count_r);
      end else if (over_limit) begin
        verdict_r <= VERDICT_OVER_LIMIT;
        kept_r    <= 9'(count_r);
      end else if (count_full) begin
        verdict_r <= VERDICT_OVERFLOW;
        kept_r    <= 9'(count_r);
      end else begin
        verdict_r <= VERDICT_KEPT;
        kept_r    <= 9'(count_r + 1'b1);
        box_mem[count_r[IW-1:0]]  <= cur_box_r;
        area_mem[count_r[IW-1:0]] <= cur_area_r;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_verdict     = verdict_r;
  assign out_kept_so_far = kept_r;

endmodule

[rtl/greedy_box_suppression_core.sv]
// A box passes the front stage (extents, then area) and then the back end's LOAD, SCAN,
// DRAIN and DONE states, the scan covering the boxes kept so far in the set; a hit ends
// the scan early. Throughput is set by the scan of the kept store, one stored box a
// cycle; a one-word front stage overlaps the next box's area with the back end's work.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Synchronous reset (rst_n low) clears the kept count and loads register defaults only.
module greedy_box_suppression_core
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT    = 256,
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_start_of_set,
  input  logic [COORD_WIDTH-1:0] in_box_left,
  input  logic [COORD_WIDTH-1:0] in_box_top,
  input  logic [COORD_WIDTH-1:0] in_box_right,
  input  logic [COORD_WIDTH-1:0] in_box_bottom,
  output logic                   out_valid,
  output logic [1:0]             out_verdict,
  output logic [8:0]             out_kept_so_far,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [15:0] thr_r;
  logic [8:0]  lim_r;
  logic        take;
  logic        q_valid, q_pop, q_sos, back_idle, front_pend_r;
  logic [4*COORD_WIDTH-1:0] q_box;
  logic [2*COORD_WIDTH+1:0] q_area;

  // One word in flight in the front stage at a time; busy until the back end takes it.
  assign busy      = q_valid || front_pend_r;
  assign take      = start && !busy;
  // Registers change only while no word is in flight.
  assign cfg_ready = back_idle && !front_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= OVERLAP_THRESHOLD_RESET;
      lim_r        <= KEEP_LIMIT_RESET;
      front_pend_r <= 1'b0;
    end else begin
      front_pend_r <= take;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OVERLAP_THRESHOLD: thr_r <= cfg_data;
          CFG_KEEP_LIMIT:        lim_r <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

  gbs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n,
    .in_take(take),
    .in_start_of_set, .in_box_left, .in_box_top, .in_box_right, .in_box_bottom,
    .q_valid, .q_pop, .q_sos, .q_box, .q_area
  );

  gbs_back #(.MAX_KEPT(MAX_KEPT), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst_n,
    .q_valid, .q_pop, .q_sos, .q_box, .q_area,
    .overlap_threshold(thr_r),
    .keep_limit(lim_r),
    .idle(back_idle),
    .out_valid, .out_verdict, .out_kept_so_far
  );

endmodule
